FILE: sv/apss_pkg.sv
package apss_pkg;

  // transfer geometry
  localparam int WORDS_PER_SECTOR = 256;

  // descriptor queue sizing
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // input item modes
  localparam logic [1:0] MODE_REQUEST = 2'd0;
  localparam logic [1:0] MODE_STATUS  = 2'd1;
  localparam logic [1:0] MODE_DATA    = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_PORT_READ  = 2'd0;
  localparam logic [1:0] KIND_PORT_WRITE = 2'd1;
  localparam logic [1:0] KIND_WORD       = 2'd2;
  localparam logic [1:0] KIND_DONE       = 2'd3;

  // completion outcomes
  localparam logic [1:0] OUTCOME_OK     = 2'd0;
  localparam logic [1:0] OUTCOME_REJECT = 2'd1;
  localparam logic [1:0] OUTCOME_FAIL   = 2'd2;

  // task-file offsets
  localparam logic [2:0] PORT_DATA     = 3'd0;
  localparam logic [2:0] PORT_COUNT    = 3'd2;
  localparam logic [2:0] PORT_LBA_LO   = 3'd3;
  localparam logic [2:0] PORT_LBA_MID  = 3'd4;
  localparam logic [2:0] PORT_LBA_HI   = 3'd5;
  localparam logic [2:0] PORT_DRIVE    = 3'd6;
  localparam logic [2:0] PORT_COMMAND  = 3'd7;

  // status bits
  localparam int ST_BSY_BIT = 7;
  localparam int ST_DRQ_BIT = 3;
  localparam int ST_ERR_BIT = 0;

  // task-file values
  localparam logic [7:0] DRIVE_SELECT = 8'hE0;
  localparam logic [3:0] LBA_TOP_MASK = 4'hF;
  localparam logic [7:0] CMD_READ     = 8'h20;
  localparam logic [7:0] CMD_WRITE    = 8'h30;

  // configuration
  localparam logic        REG_DRIVE_PRESENT = 1'b0;
  localparam logic        REG_POLL_LIMIT    = 1'b1;
  localparam logic [19:0] POLL_LIMIT_RESET  = 20'd1000000;

  typedef struct packed {
    logic        drive_present;
    logic [19:0] poll_limit;
  } cfg_t;

  // what the back end must emit for one accepted item
  typedef enum logic [2:0] {
    OP_REJECT = 3'd0,
    OP_POLL   = 3'd1,
    OP_SETUP  = 3'd2,
    OP_FAIL   = 3'd3,
    OP_DONE   = 3'd4,
    OP_FETCH  = 3'd5,
    OP_DATA   = 3'd6
  } op_t;

  // follow-up result after a data word
  typedef enum logic [1:0] {
    TAIL_NONE  = 2'd0,
    TAIL_FETCH = 2'd1,
    TAIL_POLL  = 2'd2,
    TAIL_DONE  = 2'd3
  } tail_t;

  typedef struct packed {
    op_t         op;
    tail_t       tail;
    logic        direction;
    logic [27:0] sector_address;
    logic [7:0]  sectors_left;
    logic [15:0] word;
  } desc_t;

endpackage

FILE: sv/apss_front.sv
module apss_front (
  input  logic                 clk,
  input  logic                 rst,
  input  apss_pkg::cfg_t       cfg,
  input  logic                 accept,
  input  logic [1:0]           mode,
  input  logic [27:0]          block_address,
  input  logic [7:0]           sector_total,
  input  logic                 is_write,
  input  logic [7:0]           status_byte,
  input  logic [15:0]          data_word,
  output logic                 push,
  output apss_pkg::desc_t      desc
);

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_PRE   = 6'b000010,
    PH_BSY   = 6'b000100,
    PH_DRQ   = 6'b001000,
    PH_DATA  = 6'b010000,
    PH_FINAL = 6'b100000
  } phase_t;

  phase_t      phase, phase_next;
  logic        direction, direction_next;
  logic [27:0] sector_address, sector_address_next;
  logic [7:0]  sectors_left, sectors_left_next;
  logic [7:0]  word_index, word_index_next;
  logic [19:0] polls_done, polls_done_next;

  logic [19:0] limit;
  logic [19:0] polls_inc;
  logic        expired;
  logic        bsy, drq, err;
  logic        sector_end;
  logic [7:0]  sectors_dec;

  // poll accounting: a zero limit acts as one
  assign limit      = (cfg.poll_limit == '0) ? 20'd1 : cfg.poll_limit;
  assign polls_inc  = polls_done + 20'd1;
  assign expired    = polls_inc >= limit;
  assign bsy        = status_byte[apss_pkg::ST_BSY_BIT];
  assign drq        = status_byte[apss_pkg::ST_DRQ_BIT];
  assign err        = status_byte[apss_pkg::ST_ERR_BIT];
  assign sector_end = ({1'b0, word_index} + 9'd1) >= 9'(apss_pkg::WORDS_PER_SECTOR);
  assign sectors_dec = sectors_left - 8'd1;

  // classify the item and step the transfer state
  always_comb begin
    phase_next          = phase;
    direction_next      = direction;
    sector_address_next = sector_address;
    sectors_left_next   = sectors_left;
    word_index_next     = word_index;
    polls_done_next     = polls_done;
    push                = 1'b0;
    desc.op             = apss_pkg::OP_POLL;
    desc.tail           = apss_pkg::TAIL_NONE;
    desc.direction      = direction;
    desc.sector_address = sector_address;
    desc.sectors_left   = sectors_left;
    desc.word           = data_word;
    if (accept) begin
      unique case (mode)
        apss_pkg::MODE_REQUEST: begin
          push = 1'b1;
          if (phase != PH_IDLE || !cfg.drive_present || sector_total == '0) begin
            desc.op = apss_pkg::OP_REJECT;
          end else begin
            direction_next      = is_write;
            sector_address_next = block_address;
            sectors_left_next   = sector_total;
            word_index_next     = '0;
            polls_done_next     = '0;
            phase_next          = PH_PRE;
            desc.op             = apss_pkg::OP_POLL;
          end
        end
        apss_pkg::MODE_STATUS: begin
          unique case (phase)
            PH_PRE: begin
              push = 1'b1;
              if (!bsy || expired) begin
                desc.op         = apss_pkg::OP_SETUP;
                polls_done_next = '0;
                phase_next      = PH_BSY;
              end else begin
                polls_done_next = polls_inc;
              end
            end
            PH_BSY: begin
              push = 1'b1;
              if (!bsy) begin
                polls_done_next = '0;
                phase_next      = PH_DRQ;
              end else if (expired) begin
                polls_done_next = polls_inc;
                phase_next      = PH_IDLE;
                desc.op         = apss_pkg::OP_FAIL;
              end else begin
                polls_done_next = polls_inc;
              end
            end
            PH_DRQ: begin
              polls_done_next = polls_inc;
              push            = 1'b1;
              if (err) begin
                phase_next = PH_IDLE;
                desc.op    = apss_pkg::OP_FAIL;
              end else if (drq) begin
                polls_done_next = '0;
                word_index_next = '0;
                phase_next      = PH_DATA;
                push            = !direction;
                desc.op         = apss_pkg::OP_FETCH;
              end else if (expired) begin
                phase_next = PH_IDLE;
                desc.op    = apss_pkg::OP_FAIL;
              end
            end
            PH_FINAL: begin
              polls_done_next = polls_inc;
              push            = 1'b1;
              if (!bsy || expired) begin
                phase_next = PH_IDLE;
                desc.op    = apss_pkg::OP_DONE;
              end
            end
            default: begin
              push = 1'b0;
            end
          endcase
        end
        apss_pkg::MODE_DATA: begin
          if (phase == PH_DATA) begin
            push    = 1'b1;
            desc.op = apss_pkg::OP_DATA;
            if (!sector_end) begin
              word_index_next = word_index + 8'd1;
              desc.tail       = direction ? apss_pkg::TAIL_NONE : apss_pkg::TAIL_FETCH;
            end else begin
              word_index_next   = '0;
              polls_done_next   = '0;
              sectors_left_next = sectors_dec;
              if (sectors_dec != '0) begin
                phase_next = PH_BSY;
                desc.tail  = apss_pkg::TAIL_POLL;
              end else if (direction) begin
                phase_next = PH_FINAL;
                desc.tail  = apss_pkg::TAIL_POLL;
              end else begin
                phase_next = PH_IDLE;
                desc.tail  = apss_pkg::TAIL_DONE;
              end
            end
          end
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  // transfer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      direction      <= 1'b0;
      sector_address <= '0;
      sectors_left   <= '0;
      word_index     <= '0;
      polls_done     <= '0;
    end else begin
      phase          <= phase_next;
      direction      <= direction_next;
      sector_address <= sector_address_next;
      sectors_left   <= sectors_left_next;
      word_index     <= word_index_next;
      polls_done     <= polls_done_next;
    end
  end

endmodule

FILE: sv/apss_queue.sv
module apss_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  apss_pkg::desc_t push_desc,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output apss_pkg::desc_t head
);

  apss_pkg::desc_t                   entries [apss_pkg::QUEUE_DEPTH];
  logic [apss_pkg::QUEUE_PTR_W-1:0]  wr_ptr;
  logic [apss_pkg::QUEUE_PTR_W-1:0]  rd_ptr;
  logic [apss_pkg::QUEUE_CNT_W-1:0]  count;
  logic                              do_push;
  logic                              do_pop;

  assign full       = count == apss_pkg::QUEUE_CNT_W'(apss_pkg::QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // descriptor storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + apss_pkg::QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + apss_pkg::QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + apss_pkg::QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - apss_pkg::QUEUE_CNT_W'(1);
      end
    end
  end

endmodule

FILE: sv/apss_back.sv
module apss_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  apss_pkg::desc_t head,
  output logic            pop,
  output logic            res_valid,
  input  logic            res_stall,
  output logic [1:0]      kind,
  output logic [2:0]      port_offset,
  output logic [15:0]     value,
  output logic [1:0]      outcome,
  output logic            last
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  port_offset;
    logic [15:0] value;
    logic [1:0]  outcome;
    logic        last;
  } res_t;

  logic [2:0] step;
  logic       load;
  res_t       res;

  // follow-up result after a data word
  function automatic res_t tail_result(apss_pkg::tail_t tail);
    res_t r;
    r = '0;
    r.last = 1'b1;
    unique case (tail)
      apss_pkg::TAIL_FETCH: begin
        r.kind        = apss_pkg::KIND_PORT_READ;
        r.port_offset = apss_pkg::PORT_DATA;
      end
      apss_pkg::TAIL_POLL: begin
        r.kind        = apss_pkg::KIND_PORT_READ;
        r.port_offset = apss_pkg::PORT_COMMAND;
      end
      apss_pkg::TAIL_DONE: begin
        r.kind    = apss_pkg::KIND_DONE;
        r.outcome = apss_pkg::OUTCOME_OK;
      end
      default: begin
        r.kind = apss_pkg::KIND_DONE;
      end
    endcase
    return r;
  endfunction

  // one result of a descriptor, chosen by step
  always_comb begin
    res = '0;
    unique case (head.op)
      apss_pkg::OP_REJECT: begin
        res.kind    = apss_pkg::KIND_DONE;
        res.outcome = apss_pkg::OUTCOME_REJECT;
        res.last    = 1'b1;
      end
      apss_pkg::OP_POLL: begin
        res.kind        = apss_pkg::KIND_PORT_READ;
        res.port_offset = apss_pkg::PORT_COMMAND;
        res.last        = 1'b1;
      end
      apss_pkg::OP_FAIL: begin
        res.kind    = apss_pkg::KIND_DONE;
        res.outcome = apss_pkg::OUTCOME_FAIL;
        res.last    = 1'b1;
      end
      apss_pkg::OP_DONE: begin
        res.kind    = apss_pkg::KIND_DONE;
        res.outcome = apss_pkg::OUTCOME_OK;
        res.last    = 1'b1;
      end
      apss_pkg::OP_FETCH: begin
        res.kind        = apss_pkg::KIND_PORT_READ;
        res.port_offset = apss_pkg::PORT_DATA;
        res.last        = 1'b1;
      end
      apss_pkg::OP_DATA: begin
        if (step == 3'd0) begin
          res.kind        = head.direction ? apss_pkg::KIND_PORT_WRITE
                                           : apss_pkg::KIND_WORD;
          res.port_offset = apss_pkg::PORT_DATA;
          res.value       = head.word;
          res.last        = head.tail == apss_pkg::TAIL_NONE;
        end else begin
          res = tail_result(head.tail);
        end
      end
      apss_pkg::OP_SETUP: begin
        res.kind = apss_pkg::KIND_PORT_WRITE;
        unique case (step)
          3'd0: begin
            res.port_offset = apss_pkg::PORT_DRIVE;
            res.value = {8'd0, apss_pkg::DRIVE_SELECT
                               | {4'd0, head.sector_address[27:24] & apss_pkg::LBA_TOP_MASK}};
          end
          3'd1: begin
            res.port_offset = apss_pkg::PORT_COUNT;
            res.value       = {8'd0, head.sectors_left};
          end
          3'd2: begin
            res.port_offset = apss_pkg::PORT_LBA_LO;
            res.value       = {8'd0, head.sector_address[7:0]};
          end
          3'd3: begin
            res.port_offset = apss_pkg::PORT_LBA_MID;
            res.value       = {8'd0, head.sector_address[15:8]};
          end
          3'd4: begin
            res.port_offset = apss_pkg::PORT_LBA_HI;
            res.value       = {8'd0, head.sector_address[23:16]};
          end
          3'd5: begin
            res.port_offset = apss_pkg::PORT_COMMAND;
            res.value = {8'd0, head.direction ? apss_pkg::CMD_WRITE : apss_pkg::CMD_READ};
          end
          default: begin
            res.kind        = apss_pkg::KIND_PORT_READ;
            res.port_offset = apss_pkg::PORT_COMMAND;
            res.last        = 1'b1;
          end
        endcase
      end
      default: begin
        res.kind = apss_pkg::KIND_DONE;
        res.last = 1'b1;
      end
    endcase
  end

  // output register takes a new result whenever it is empty or moving
  assign load = !res_valid || !res_stall;
  assign pop  = head_valid && load && res.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      step      <= '0;
    end else if (load) begin
      res_valid <= head_valid;
      if (head_valid) begin
        step <= res.last ? 3'd0 : step + 3'd1;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      kind        <= res.kind;
      port_offset <= res.port_offset;
      value       <= res.value;
      outcome     <= res.outcome;
      last        <= res.last;
    end
  end

endmodule

FILE: sv/ata_pio_sector_sequencer_unit.sv
// channel   direction  handshake              payload
// req       in         req_valid / req_stall  mode block_address sector_total is_write
//                                             status_byte data_word
// res       out        res_valid / res_stall  kind port_offset value outcome last
// cfg       in         psel penable pwrite    paddr pwdata prdata pready
//
// the front end takes one item per cycle while its four-entry descriptor queue has room
// the back end sends one result per cycle while res_stall is low; an item yields up to
// seven results, none when dropped, seven for task-file setup after the first status poll
// the back end's single result register sets the rate: one result a cycle unless stalled
// synchronous reset empties the queue and output register and returns to idle
// req_stall is high only while the descriptor queue is full
module ata_pio_sector_sequencer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  mode,
  input  logic [27:0] block_address,
  input  logic [7:0]  sector_total,
  input  logic        is_write,
  input  logic [7:0]  status_byte,
  input  logic [15:0] data_word,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [1:0]  kind,
  output logic [2:0]  port_offset,
  output logic [15:0] value,
  output logic [1:0]  outcome,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  apss_pkg::cfg_t  cfg;
  apss_pkg::desc_t push_desc;
  apss_pkg::desc_t head;
  logic            push;
  logic            full;
  logic            pop;
  logic            head_valid;
  logic            accept;
  logic            cfg_write;

  // configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drive_present <= 1'b0;
      cfg.poll_limit    <= apss_pkg::POLL_LIMIT_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == apss_pkg::REG_DRIVE_PRESENT) begin
        cfg.drive_present <= pwdata[0];
      end else begin
        cfg.poll_limit <= pwdata[19:0];
      end
    end
  end

  assign prdata = (paddr[2] == apss_pkg::REG_POLL_LIMIT) ? {12'd0, cfg.poll_limit}
                                                         : {31'd0, cfg.drive_present};

  // input transfer
  assign req_stall = full;
  assign accept    = req_valid && !req_stall;

  apss_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .accept        (accept),
    .mode          (mode),
    .block_address (block_address),
    .sector_total  (sector_total),
    .is_write      (is_write),
    .status_byte   (status_byte),
    .data_word     (data_word),
    .push          (push),
    .desc          (push_desc)
  );

  apss_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (push_desc),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  apss_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .kind        (kind),
    .port_offset (port_offset),
    .value       (value),
    .outcome     (outcome),
    .last        (last)
  );

endmodule
